// ===== rtl/scsc_pkg.sv =====
// shared types and constants of the shell command syntax checker
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package scsc_pkg;

    // line limit and group nesting limit
    localparam int LINE_BYTES = 1024;
    localparam int MAX_DEPTH  = 255;
    localparam int POS_W      = $clog2(LINE_BYTES);
    localparam int DEPTH_W    = 8;

    // special bytes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0a;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_SEMI  = 8'h3b;
    localparam logic [7:0] CH_BAR   = 8'h7c;

    typedef enum logic [2:0] {
        PH_START = 3'd0,
        PH_NEED  = 3'd1,
        PH_WORD  = 3'd2,
        PH_GROUP = 3'd3,
        PH_AMP   = 3'd4,
        PH_BAD   = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        TK_AND   = 3'd0,
        TK_OR    = 3'd1,
        TK_SEMI  = 3'd2,
        TK_AMP   = 3'd3,
        TK_OPEN  = 3'd4,
        TK_CLOSE = 3'd5,
        TK_WORD  = 3'd6
    } tok_class_t;

    // bytes collected for the current token
    typedef struct packed {
        logic [1:0] len;
        logic [7:0] first;
        logic [7:0] second;
    } token_t;

    // grammar state handed between top level and grammar step
    typedef struct packed {
        phase_t              phase;
        logic [DEPTH_W-1:0]  depth;
    } gram_state_t;

endpackage

`default_nettype wire

// ===== rtl/scsc_if.sv =====
// handshake channels of the syntax checker: command bytes in, verdict out
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface scsc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       last;

    modport source (output valid, output ch, output last, input ready);
    modport sink   (input valid, input ch, input last, output ready);
endinterface

interface scsc_out_if;
    logic valid;
    logic ready;
    logic valid_res;

    modport source (output valid, output valid_res, input ready);
    modport sink   (input valid, input valid_res, output ready);
endinterface

`default_nettype wire

// ===== rtl/scsc_grammar.sv =====
// one grammar step: classifies a finished token and advances phase and depth
// depends on scsc_pkg
`timescale 1ns / 1ps
`default_nettype none

module scsc_grammar (
    input  wire  scsc_pkg::token_t      tok,
    input  wire  scsc_pkg::gram_state_t cur,
    output scsc_pkg::gram_state_t       nxt
);
    import scsc_pkg::*;

    tok_class_t cls;

    // token class from its length and first two bytes
    always_comb
    begin
        cls = TK_WORD;
        if (tok.len == 2'd1)
        begin
            case (tok.first)
                CH_AMP:   cls = TK_AMP;
                CH_SEMI:  cls = TK_SEMI;
                CH_OPEN:  cls = TK_OPEN;
                CH_CLOSE: cls = TK_CLOSE;
                default:  cls = TK_WORD;
            endcase
        end
        else if (tok.len == 2'd2)
        begin
            if (tok.first == CH_AMP && tok.second == CH_AMP)
                cls = TK_AND;
            else if (tok.first == CH_BAR && tok.second == CH_BAR)
                cls = TK_OR;
        end
    end

    // phase transition and group depth update
    always_comb
    begin
        nxt = cur;
        case (cur.phase)
            PH_START, PH_NEED:
            begin
                if (cls == TK_OPEN)
                begin
                    if (cur.depth >= DEPTH_W'(MAX_DEPTH))
                        nxt.phase = PH_BAD;
                    else
                    begin
                        nxt.depth = cur.depth + 1'b1;
                        nxt.phase = PH_NEED;
                    end
                end
                else if (cls == TK_WORD)
                    nxt.phase = PH_WORD;
                else
                    nxt.phase = PH_BAD;
            end
            PH_WORD, PH_GROUP:
            begin
                if (cls inside {TK_AND, TK_OR, TK_SEMI})
                    nxt.phase = PH_NEED;
                else if (cls == TK_CLOSE)
                begin
                    if (cur.depth != '0)
                    begin
                        nxt.depth = cur.depth - 1'b1;
                        nxt.phase = PH_GROUP;
                    end
                    else
                        nxt.phase = PH_BAD;
                end
                else if (cls == TK_AMP)
                    nxt.phase = (cur.depth == '0) ? PH_AMP : PH_BAD;
                else if (cur.phase != PH_WORD)
                    nxt.phase = PH_BAD;
            end
            default:
                nxt.phase = PH_BAD;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/shell_command_syntax_check_unit.sv =====
// top level of the shell command syntax checker
// depends on scsc_pkg, scsc_if and scsc_grammar
//
// usage:
//   cmd carries one byte of a command line per item (ch) with last marking
//   the final byte of the line; verdict carries one item per line, valid_res
//   is 1 when the line is syntactically valid
//   tokens split on space, tab and newline; a zero byte ends the string and
//   the bytes after it, or after the first LINE_BYTES-1 bytes, are ignored
// timing:
//   a byte is taken into an input register, then the grammar logic updates the
//   token and parse state; the verdict is written to the output register when
//   the last byte leaves the input register; throughput is one byte per cycle,
//   set by the single grammar step per byte, while no last byte waits on the output
// reset:
//   rst_n clears the parse state and both valid flags; after each verdict the
//   state returns to its reset value for the next line
// stall:
//   while the verdict waits to be taken, bytes keep flowing; only a second
//   last byte waits in the input register until the output frees up
`timescale 1ns / 1ps
`default_nettype none

module shell_command_syntax_check_unit (
    input  wire              clk,
    input  wire              rst_n,
    scsc_in_if.sink          cmd,
    scsc_out_if.source       verdict
);
    import scsc_pkg::*;

    // input register
    logic       in_valid_reg;
    logic [7:0] ch_reg;
    logic       last_reg;

    // parse state
    token_t            tok_reg, tok_next;
    gram_state_t       gram_reg, gram_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              ended_reg, ended_next;

    // output register
    logic out_valid_reg;
    logic res_reg, res_next;

    logic        stage_go;
    logic        process;
    logic        end_old;
    logic        take_en;
    token_t      tok_upd;
    token_t      take_tok;
    gram_state_t gram_step;
    gram_state_t gram_fin;

    // the stage moves unless a verdict is blocked by a full output
    assign stage_go  = in_valid_reg && (!last_reg || !out_valid_reg || verdict.ready);
    assign cmd.ready = !in_valid_reg || stage_go;

    assign verdict.valid     = out_valid_reg;
    assign verdict.valid_res = res_reg;

    // byte handling and token collection
    always_comb
    begin
        process    = !ended_reg && (pos_reg < POS_W'(LINE_BYTES - 1));
        tok_upd    = tok_reg;
        pos_next   = pos_reg;
        ended_next = ended_reg;
        end_old    = 1'b0;
        if (process)
        begin
            pos_next = pos_reg + 1'b1;
            if (ch_reg inside {CH_NUL, CH_SPACE, CH_TAB, CH_NL})
            begin
                end_old = 1'b1;
                tok_upd = '0;
                if (ch_reg == CH_NUL)
                    ended_next = 1'b1;
            end
            else
            begin
                if (tok_reg.len == 2'd0)
                    tok_upd.first = ch_reg;
                else if (tok_reg.len == 2'd1)
                    tok_upd.second = ch_reg;
                if (tok_reg.len != 2'd3)
                    tok_upd.len = tok_reg.len + 1'b1;
            end
        end
        // line position starts over after the last byte
        if (last_reg)
        begin
            pos_next   = '0;
            ended_next = 1'b0;
        end
        // at most one token ends per byte: at a separator, or at the last byte
        take_tok = end_old ? tok_reg : tok_upd;
        take_en  = end_old ? (tok_reg.len != 2'd0) : (last_reg && tok_upd.len != 2'd0);
    end

    scsc_grammar u_grammar (
        .tok (take_tok),
        .cur (gram_reg),
        .nxt (gram_step)
    );

    // verdict and return to the start of a line
    always_comb
    begin
        gram_fin = take_en ? gram_step : gram_reg;
        res_next = (gram_fin.phase == PH_START) || (gram_fin.phase == PH_AMP) ||
                   ((gram_fin.phase == PH_WORD || gram_fin.phase == PH_GROUP) &&
                    gram_fin.depth == '0);
        tok_next  = (last_reg || take_en) ? '0 : tok_upd;
        gram_next = gram_fin;
        if (last_reg)
            gram_next = '{phase: PH_START, depth: '0};
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (cmd.ready)
            in_valid_reg <= cmd.valid;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ready && cmd.valid)
        begin
            ch_reg   <= cmd.ch;
            last_reg <= cmd.last;
        end
    end

    // parse state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg   <= '0;
            gram_reg  <= '{phase: PH_START, depth: '0};
            pos_reg   <= '0;
            ended_reg <= 1'b0;
        end
        else if (stage_go)
        begin
            tok_reg   <= tok_next;
            gram_reg  <= gram_next;
            pos_reg   <= pos_next;
            ended_reg <= ended_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (stage_go && last_reg)
            out_valid_reg <= 1'b1;
        else if (verdict.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (stage_go && last_reg)
            res_reg <= res_next;
    end

endmodule

`default_nettype wire
